FILE: rtl/core/aopb_pkg.sv
// Package: shared types and constants for the alpha-over pixel blend unit.
package aopb_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned N_CH    = 3;
  localparam int unsigned NUM_W   = 24;
  localparam int unsigned WGT_W   = 17;
  localparam int unsigned QUOT_W  = 8;
  localparam int unsigned RECIP_W = 16;
  localparam int unsigned RECIP_SH = 23;

  localparam logic [CH_W-1:0]    CH_MAX = 8'd255;
  // floor(w/255) == (w * 0x8081) >> 23 for every w up to 255*255
  localparam logic [RECIP_W-1:0] RECIP  = 16'h8081;

  typedef struct packed {
    logic [CH_W-1:0] src_red;
    logic [CH_W-1:0] src_green;
    logic [CH_W-1:0] src_blue;
    logic [CH_W-1:0] src_alpha;
    logic [CH_W-1:0] dst_red;
    logic [CH_W-1:0] dst_green;
    logic [CH_W-1:0] dst_blue;
    logic [CH_W-1:0] dst_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
    logic            written;
  } pix_out_t;

  // divider pipeline payload; dvs is the divisor aligned to the current quotient bit
  typedef struct packed {
    logic [N_CH-1:0][NUM_W-1:0]  rem;
    logic [NUM_W-1:0]            dvs;
    logic [N_CH-1:0][QUOT_W-1:0] quot;
    logic [CH_W-1:0]             alpha;
    logic                        written;
  } div_t;

endpackage

FILE: rtl/core/aopb_if.sv
// Interfaces: valid/ready request channels for input and result pixels.
interface aopb_in_if;
  logic              valid;
  logic              ready;
  aopb_pkg::pix_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aopb_out_if;
  logic               valid;
  logic               ready;
  aopb_pkg::pix_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/alpha_over_pixel_blend_unit.sv
// Top level: Porter-Duff over of a straight-alpha RGBA8 source onto a destination.
//
// in_chan carries one request per pixel pair (source and destination RGBA8),
// out_chan one result per request, in order: blended RGBA8 plus a written flag.
// A source alpha of zero returns the destination unchanged with written low.
// The path from acceptance to out_chan.valid runs through three front stages
// (multiplies, weight and numerator sums, reciprocal alpha) and eight divider
// stages, each resolving one quotient bit of the three color divisions.
// Throughput is one pixel per cycle while out_chan is not stalled; the eight-stage divider sets the latency.
// Every stage has its own valid bit and loads when empty or when the stage
// after it moves, so bubbles close up and in_chan.ready stays high while the
// pipeline has a free slot, even when out_chan is stalled. A stalled result
// holds on out_chan until taken; nothing is dropped or repeated.
// Synchronous reset clears all valid bits; the data registers are not reset.
module alpha_over_pixel_blend_unit (
  input  logic       clk,
  input  logic       rst_n,
  aopb_in_if.sink    in_chan,
  aopb_out_if.source out_chan
);

  localparam int unsigned N_STG = aopb_pkg::QUOT_W;

  logic           stg_vld [N_STG+1];
  logic           stg_rdy [N_STG+1];
  aopb_pkg::div_t stg_dat [N_STG+1];

  aopb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_data  (in_chan.data),
    .up_ready (in_chan.ready),
    .dn_valid (stg_vld[0]),
    .dn_data  (stg_dat[0]),
    .dn_ready (stg_rdy[0])
  );

  for (genvar i = 0; i < N_STG; i++) begin : g_div
    aopb_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_vld[i]),
      .up_data  (stg_dat[i]),
      .up_ready (stg_rdy[i]),
      .dn_valid (stg_vld[i+1]),
      .dn_data  (stg_dat[i+1]),
      .dn_ready (stg_rdy[i+1])
    );
  end

  assign stg_rdy[N_STG] = out_chan.ready;
  assign out_chan.valid = stg_vld[N_STG];

  always_comb begin
    out_chan.data.out_red   = stg_dat[N_STG].quot[0];
    out_chan.data.out_green = stg_dat[N_STG].quot[1];
    out_chan.data.out_blue  = stg_dat[N_STG].quot[2];
    out_chan.data.out_alpha = stg_dat[N_STG].alpha;
    out_chan.data.written   = stg_dat[N_STG].written;
  end

endmodule

FILE: rtl/core/aopb_front.sv
// Front end: weight and numerator products, output alpha, divider setup (3 stages).
module aopb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  aopb_pkg::pix_in_t up_data,
  output logic              up_ready,
  output logic              dn_valid,
  output aopb_pkg::div_t    dn_data,
  input  logic              dn_ready
);

  typedef struct packed {
    logic [aopb_pkg::N_CH-1:0][2*aopb_pkg::CH_W-1:0] psc;
    logic [aopb_pkg::N_CH-1:0][aopb_pkg::CH_W-1:0]   dc;
    logic [2*aopb_pkg::CH_W-1:0]                     dw;
    logic [aopb_pkg::CH_W-1:0]                       sa;
    logic [aopb_pkg::CH_W-1:0]                       da;
    logic                                            skip;
  } s1_t;

  typedef struct packed {
    logic [aopb_pkg::N_CH-1:0][aopb_pkg::NUM_W-1:0] num;
    logic [aopb_pkg::WGT_W-1:0]                     w;
    logic [aopb_pkg::CH_W-1:0]                      da;
    logic                                           skip;
  } s2_t;

  logic s1_vld_r, s1_vld_nxt, s2_vld_r, s2_vld_nxt, s3_vld_r, s3_vld_nxt;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  aopb_pkg::div_t s3_r, s3_nxt;
  logic s1_ld, s2_ld, s3_ld;
  logic [aopb_pkg::WGT_W+aopb_pkg::RECIP_W-1:0] alpha_prod;

  assign s3_ld    = !s3_vld_r || dn_ready;
  assign s2_ld    = !s2_vld_r || s3_ld;
  assign s1_ld    = !s1_vld_r || s2_ld;
  assign up_ready = s1_ld;

  assign s1_vld_nxt = s1_ld ? up_valid : s1_vld_r;
  assign s2_vld_nxt = s2_ld ? s1_vld_r : s2_vld_r;
  assign s3_vld_nxt = s3_ld ? s2_vld_r : s3_vld_r;

  // stage 1: source color times alpha, destination weight
  always_comb begin
    s1_nxt.sa   = up_data.src_alpha;
    s1_nxt.da   = up_data.dst_alpha;
    s1_nxt.skip = (up_data.src_alpha == '0);
    s1_nxt.dc   = {up_data.dst_blue, up_data.dst_green, up_data.dst_red};
    s1_nxt.psc[0] = 16'(up_data.src_red)   * 16'(up_data.src_alpha);
    s1_nxt.psc[1] = 16'(up_data.src_green) * 16'(up_data.src_alpha);
    s1_nxt.psc[2] = 16'(up_data.src_blue)  * 16'(up_data.src_alpha);
    s1_nxt.dw   = 16'(up_data.dst_alpha) * 16'(aopb_pkg::CH_MAX - up_data.src_alpha);
  end

  // stage 2: numerators and total weight; skip turns into dc*255 / 255
  always_comb begin
    s2_nxt.da   = s1_r.da;
    s2_nxt.skip = s1_r.skip;
    for (int c = 0; c < aopb_pkg::N_CH; c++) begin
      if (s1_r.skip) begin
        s2_nxt.num[c] = {8'd0, s1_r.dc[c], 8'd0} - {16'd0, s1_r.dc[c]};
      end else begin
        s2_nxt.num[c] = {s1_r.psc[c], 8'd0} - {8'd0, s1_r.psc[c]}
                        + 24'(s1_r.dc[c]) * 24'(s1_r.dw);
      end
    end
    if (s1_r.skip) begin
      s2_nxt.w = 17'(aopb_pkg::CH_MAX);
    end else begin
      s2_nxt.w = {1'b0, s1_r.sa, 8'd0} - {9'd0, s1_r.sa} + {1'b0, s1_r.dw};
    end
  end

  // stage 3: output alpha by reciprocal, divisor aligned to quotient msb
  assign alpha_prod = 33'(s2_r.w) * 33'(aopb_pkg::RECIP);

  always_comb begin
    s3_nxt.rem     = s2_r.num;
    s3_nxt.dvs     = {s2_r.w, 7'd0};
    s3_nxt.quot    = '0;
    s3_nxt.written = !s2_r.skip;
    s3_nxt.alpha   = s2_r.skip ? s2_r.da
                               : alpha_prod[aopb_pkg::RECIP_SH +: aopb_pkg::CH_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
      s3_vld_r <= s3_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld) s1_r <= s1_nxt;
    if (s2_ld) s2_r <= s2_nxt;
    if (s3_ld) s3_r <= s3_nxt;
  end

  assign dn_valid = s3_vld_r;
  assign dn_data  = s3_r;

endmodule

FILE: rtl/core/aopb_div_stage.sv
// Divider stage: one restoring quotient bit for all three color channels.
module aopb_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  input  aopb_pkg::div_t up_data,
  output logic           up_ready,
  output logic           dn_valid,
  output aopb_pkg::div_t dn_data,
  input  logic           dn_ready
);

  logic           vld_r, vld_nxt, ld;
  aopb_pkg::div_t dat_r, dat_nxt;
  logic [aopb_pkg::NUM_W:0] trial [aopb_pkg::N_CH];

  assign ld       = !vld_r || dn_ready;
  assign up_ready = ld;
  assign vld_nxt  = ld ? up_valid : vld_r;

  always_comb begin
    dat_nxt         = up_data;
    dat_nxt.dvs     = up_data.dvs >> 1;
    for (int c = 0; c < aopb_pkg::N_CH; c++) begin
      trial[c] = {1'b0, up_data.rem[c]} - {1'b0, up_data.dvs};
      dat_nxt.quot[c] = {up_data.quot[c][aopb_pkg::QUOT_W-2:0], !trial[c][aopb_pkg::NUM_W]};
      if (!trial[c][aopb_pkg::NUM_W]) begin
        dat_nxt.rem[c] = trial[c][aopb_pkg::NUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) dat_r <= dat_nxt;
  end

  assign dn_valid = vld_r;
  assign dn_data  = dat_r;

endmodule
